[hw/rtl/grse_pkg.sv]
// grse_pkg: shared types, codes and the run finder of the glyph row span emitter
// used by every module of the block; depends on nothing else
package grse_pkg;

   // geometry constants
   localparam int COORD_BITS  = 13;
   localparam int GLYPH_ROWS  = 16;
   localparam int CELL_WIDE   = 16;
   localparam int CELL_NARROW = 8;
   localparam int SPAN_BITS   = 9;   // holds GLYPH_ROWS * 15 and 16 * 15

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [COORD_BITS:0]   coord_ext_type;
   typedef logic [SPAN_BITS-1:0]  span_type;

   // function codes
   localparam logic [1:0] FUNC_ROW   = 2'd0;
   localparam logic [1:0] FUNC_CLEAR = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;

   // register indexes
   localparam logic [1:0] REG_SCALE         = 2'd0;
   localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd1;
   localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd2;

   // reset values of the registers
   localparam logic [3:0] SCALE_RESET         = 4'd2;
   localparam coord_type  SCREEN_WIDTH_RESET  = coord_type'(1024);
   localparam coord_type  SCREEN_HEIGHT_RESET = coord_type'(768);

   typedef struct packed {
      logic [1:0]  func;
      logic [11:0] pos_x;
      logic [11:0] pos_y;
      logic [15:0] row_bits;
      logic        wide;
      logic [3:0]  row_index;
      logic        first_row;
   } req_type;

   typedef struct packed {
      coord_type rect_x;
      coord_type rect_y;
      coord_type rect_w;
      coord_type rect_h;
      logic      is_foreground;
      logic      damage_valid;
      logic      last;
   } rsp_type;

   // unclipped rectangle offered to the clip unit
   typedef struct packed {
      coord_type x0;
      coord_type y0;
      span_type  w;
      span_type  h;
   } cand_type;

   // clipped rectangle with exclusive right and bottom edges
   typedef struct packed {
      logic      keep;
      coord_type x0;
      coord_type y0;
      coord_type x1;
      coord_type y1;
   } clip_type;

   // damage box commands from the sequencer
   typedef struct packed {
      logic      clear;
      logic      add;
      coord_type x0;
      coord_type y0;
      coord_type x1;
      coord_type y1;
   } dmg_cmd_type;

   typedef struct packed {
      logic      present;
      coord_type left;
      coord_type top;
      coord_type right;
      coord_type bottom;
   } dmg_box_type;

   typedef struct packed {
      logic idle;
      logic pend_valid;
   } seq_stat_type;

   typedef struct packed {
      logic       found;
      logic [3:0] start;
      logic [4:0] stop;
   } run_type;

   // next run of set columns at or after col, column i is bit 15 - i
   function automatic run_type find_run(input logic [15:0] bits, input logic wide,
                                        input logic [4:0] col);
      logic [15:0] set_cols;
      logic [15:0] gap_cols;
      logic        in_cell;
      run_type     r;
      r = '0;
      for (int i = 0; i < 16; i++) begin
         in_cell     = wide || (i < CELL_NARROW);
         set_cols[i] = bits[15-i] && in_cell && (i >= int'(col));
         gap_cols[i] = !(bits[15-i] && in_cell);
      end
      for (int i = 0; i < 16; i++) begin
         if (set_cols[i] && !r.found) begin
            r.found = 1'b1;
            r.start = 4'(i);
         end
      end
      r.stop = wide ? 5'(CELL_WIDE) : 5'(CELL_NARROW);
      for (int i = 15; i >= 0; i--) begin
         if (gap_cols[i] && (i > int'(r.start))) begin
            r.stop = 5'(i);
         end
      end
      return r;
   endfunction

endpackage

[hw/rtl/glyph_row_span_emitter.sv]
// glyph_row_span_emitter: top level, configuration registers, damage box and sequencer
// depends on grse_pkg, grse_damage_box, grse_seq
//
//   channel   ports                              direction
//   req       req_valid, req_ready, req_data     in, one glyph row or damage command
//   rsp       rsp_valid, rsp_ready, rsp_data     out, one rectangle or damage report
//   csr       csr_write_en, csr_index, csr_wdata in, register writes, no read-back
//
// a glyph row is accepted in the idle state, then the background rectangle is made if
// first_row is set, then each run of set columns in turn; once no further run is found
// the held result, if any, is handed over as the final one; each rectangle goes through
// the one clip unit in its own step. clear is done on acceptance, read goes through a read state.
// reset is synchronous and active high, empties the damage box and loads the register
// reset values.
// a stalled rsp holds the sequencer once the held result and the output are both full.
module glyph_row_span_emitter (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  grse_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output grse_pkg::rsp_type   rsp_data,
   input  logic                csr_write_en,
   input  logic [1:0]          csr_index,
   input  grse_pkg::coord_type csr_wdata
);

   logic [3:0]             scale_ff;
   grse_pkg::coord_type    screen_width_ff;
   grse_pkg::coord_type    screen_height_ff;
   grse_pkg::dmg_cmd_type  dmg_cmd;
   grse_pkg::dmg_box_type  dmg_box;
   grse_pkg::seq_stat_type stat;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff         <= grse_pkg::SCALE_RESET;
         screen_width_ff  <= grse_pkg::SCREEN_WIDTH_RESET;
         screen_height_ff <= grse_pkg::SCREEN_HEIGHT_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            grse_pkg::REG_SCALE:         scale_ff         <= csr_wdata[3:0];
            grse_pkg::REG_SCREEN_WIDTH:  screen_width_ff  <= csr_wdata;
            grse_pkg::REG_SCREEN_HEIGHT: screen_height_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // damage box
   grse_damage_box u_damage (
      .clock (clock),
      .reset (reset),
      .cmd   (dmg_cmd),
      .box   (dmg_box)
   );

   // sequencer with the shared clip unit
   grse_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .scale         (scale_ff),
      .screen_width  (screen_width_ff),
      .screen_height (screen_height_ff),
      .dmg_box       (dmg_box),
      .dmg_cmd       (dmg_cmd),
      .stat          (stat)
   );

   // no result is held back while waiting for a new transaction
   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      stat.idle |-> !stat.pend_valid)
      else $error("result held back while idle");

   // a recorded box always has area, an empty one is all zero
   a_box_shape: assert property (@(posedge clock) disable iff (reset)
      dmg_box.present |-> (dmg_box.right > dmg_box.left) && (dmg_box.bottom > dmg_box.top))
      else $error("damage box without area");

   a_box_empty: assert property (@(posedge clock) disable iff (reset)
      !dmg_box.present |-> (dmg_box.left == '0) && (dmg_box.top == '0)
                           && (dmg_box.right == '0) && (dmg_box.bottom == '0))
      else $error("empty damage box not zero");

   // a clear transaction empties the box
   a_clear: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.func == grse_pkg::FUNC_CLEAR)
      |=> !dmg_box.present)
      else $error("damage box not cleared");

   // a damage report is always a final background-class result
   a_report: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.damage_valid |-> rsp_data.last && !rsp_data.is_foreground)
      else $error("damage report malformed");

endmodule

[hw/rtl/grse_clip_unit.sv]
// grse_clip_unit: shared clip unit, limits one rectangle to the screen
// depends on grse_pkg
module grse_clip_unit (
   input  grse_pkg::cand_type  cand,
   input  grse_pkg::coord_type x_limit,
   input  grse_pkg::coord_type y_limit,
   output grse_pkg::clip_type  clip
);

   grse_pkg::coord_ext_type x_end;
   grse_pkg::coord_ext_type y_end;
   grse_pkg::coord_ext_type x_cut;
   grse_pkg::coord_ext_type y_cut;

   // far edges, then limited to the screen
   always_comb begin
      x_end = {1'b0, cand.x0} + grse_pkg::coord_ext_type'(cand.w);
      y_end = {1'b0, cand.y0} + grse_pkg::coord_ext_type'(cand.h);
      x_cut = (x_end < {1'b0, x_limit}) ? x_end : {1'b0, x_limit};
      y_cut = (y_end < {1'b0, y_limit}) ? y_end : {1'b0, y_limit};
   end

   // rectangle survives only with some area left
   always_comb begin
      clip.x0   = cand.x0;
      clip.y0   = cand.y0;
      clip.x1   = x_cut[grse_pkg::COORD_BITS-1:0];
      clip.y1   = y_cut[grse_pkg::COORD_BITS-1:0];
      clip.keep = (x_cut > {1'b0, cand.x0}) && (y_cut > {1'b0, cand.y0});
   end

endmodule

[hw/rtl/grse_damage_box.sv]
// grse_damage_box: damage bounding box, widened by each emitted rectangle
// depends on grse_pkg
module grse_damage_box (
   input  logic                  clock,
   input  logic                  reset,
   input  grse_pkg::dmg_cmd_type cmd,
   output grse_pkg::dmg_box_type box
);

   grse_pkg::dmg_box_type box_ff;
   grse_pkg::dmg_box_type box_in;

   // clear, first rectangle or merge
   always_comb begin
      box_in = box_ff;
      if (cmd.clear) begin
         box_in = '0;
      end else if (cmd.add) begin
         if (!box_ff.present) begin
            box_in.present = 1'b1;
            box_in.left    = cmd.x0;
            box_in.top     = cmd.y0;
            box_in.right   = cmd.x1;
            box_in.bottom  = cmd.y1;
         end else begin
            if (cmd.x0 < box_ff.left)   box_in.left   = cmd.x0;
            if (cmd.y0 < box_ff.top)    box_in.top    = cmd.y0;
            if (cmd.x1 > box_ff.right)  box_in.right  = cmd.x1;
            if (cmd.y1 > box_ff.bottom) box_in.bottom = cmd.y1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff <= '0;
      end else begin
         box_ff <= box_in;
      end
   end

   assign box = box_ff;

endmodule

[hw/rtl/grse_seq.sv]
// grse_seq: sequencer that walks background and runs through the shared clip unit,
// holds one result back so the final one can be marked; depends on grse_pkg, grse_clip_unit
module grse_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  grse_pkg::req_type      req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output grse_pkg::rsp_type      rsp_data,
   input  logic [3:0]             scale,
   input  grse_pkg::coord_type    screen_width,
   input  grse_pkg::coord_type    screen_height,
   input  grse_pkg::dmg_box_type  dmg_box,
   output grse_pkg::dmg_cmd_type  dmg_cmd,
   output grse_pkg::seq_stat_type stat
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_BACK  = 3'd1;
   localparam logic [2:0] ST_RUNS  = 3'd2;
   localparam logic [2:0] ST_FLUSH = 3'd3;
   localparam logic [2:0] ST_READ  = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [4:0]        col_ff, col_in;
   grse_pkg::req_type req_ff, req_in;
   logic              pend_valid_ff, pend_valid_in;
   grse_pkg::rsp_type pend_ff, pend_in;
   logic              out_valid_ff, out_valid_in;
   grse_pkg::rsp_type out_ff, out_in;

   grse_pkg::run_type  run;
   grse_pkg::cand_type cand;
   grse_pkg::clip_type clip;
   grse_pkg::rsp_type  cand_rsp;
   grse_pkg::rsp_type  read_rsp;
   grse_pkg::coord_type row_y;
   logic               out_free;
   logic               step_ok;
   logic               commit;

   // next run of the latched row
   assign run = grse_pkg::find_run(req_ff.row_bits, req_ff.wide, col_ff);

   // candidate rectangle: whole scaled cell, or one scaled run
   always_comb begin
      row_y = {1'b0, req_ff.pos_y}
              + grse_pkg::coord_type'(grse_pkg::span_type'(req_ff.row_index)
                                      * grse_pkg::span_type'(scale));
      if (state_ff == ST_BACK) begin
         cand.x0 = {1'b0, req_ff.pos_x};
         cand.y0 = {1'b0, req_ff.pos_y};
         cand.w  = req_ff.wide
                   ? grse_pkg::span_type'(grse_pkg::CELL_WIDE * int'(scale))
                   : grse_pkg::span_type'(grse_pkg::CELL_NARROW * int'(scale));
         cand.h  = grse_pkg::span_type'(grse_pkg::GLYPH_ROWS * int'(scale));
      end else begin
         cand.x0 = {1'b0, req_ff.pos_x}
                   + grse_pkg::coord_type'(grse_pkg::span_type'(run.start)
                                           * grse_pkg::span_type'(scale));
         cand.y0 = row_y;
         cand.w  = grse_pkg::span_type'(run.stop - 5'(run.start))
                   * grse_pkg::span_type'(scale);
         cand.h  = grse_pkg::span_type'(scale);
      end
   end

   // clip limits are the screen size, which never exceeds the coordinate range
   grse_clip_unit u_clip (
      .cand    (cand),
      .x_limit (screen_width),
      .y_limit (screen_height),
      .clip    (clip)
   );

   // result words
   always_comb begin
      cand_rsp.rect_x        = clip.x0;
      cand_rsp.rect_y        = clip.y0;
      cand_rsp.rect_w        = clip.x1 - clip.x0;
      cand_rsp.rect_h        = clip.y1 - clip.y0;
      cand_rsp.is_foreground = (state_ff == ST_RUNS);
      cand_rsp.damage_valid  = 1'b0;
      cand_rsp.last          = 1'b0;

      read_rsp.rect_x        = dmg_box.left;
      read_rsp.rect_y        = dmg_box.top;
      read_rsp.rect_w        = dmg_box.right - dmg_box.left;
      read_rsp.rect_h        = dmg_box.bottom - dmg_box.top;
      read_rsp.is_foreground = 1'b0;
      read_rsp.damage_valid  = dmg_box.present;
      read_rsp.last          = 1'b1;
   end

   assign out_free = !out_valid_ff || rsp_ready;
   assign step_ok  = !pend_valid_ff || out_free;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      col_in        = col_ff;
      req_in        = req_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_in        = out_ff;
      commit        = 1'b0;
      dmg_cmd       = '0;
      dmg_cmd.x0    = clip.x0;
      dmg_cmd.y0    = clip.y0;
      dmg_cmd.x1    = clip.x1;
      dmg_cmd.y1    = clip.y1;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               col_in = '0;
               case (req_data.func)
                  grse_pkg::FUNC_ROW: begin
                     state_in = req_data.first_row ? ST_BACK : ST_RUNS;
                  end
                  grse_pkg::FUNC_CLEAR: begin
                     dmg_cmd.clear = 1'b1;
                  end
                  grse_pkg::FUNC_READ: begin
                     state_in = ST_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_BACK: begin
            if (step_ok) begin
               commit   = clip.keep;
               state_in = ST_RUNS;
            end
         end
         ST_RUNS: begin
            if (!run.found) begin
               state_in = ST_FLUSH;
            end else if (step_ok) begin
               commit = clip.keep;
               col_in = run.stop;
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_in        = pend_ff;
               out_in.last   = 1'b1;
               out_valid_in  = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         ST_READ: begin
            if (out_free) begin
               out_in       = read_rsp;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a kept rectangle pushes the held one out and takes its place
      if (commit) begin
         if (pend_valid_ff) begin
            out_in       = pend_ff;
            out_valid_in = 1'b1;
         end
         pend_in       = cand_rsp;
         pend_valid_in = 1'b1;
         dmg_cmd.add   = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         col_ff        <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         col_ff        <= col_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = out_valid_ff;
   assign rsp_data        = out_ff;
   assign stat.idle       = (state_ff == ST_IDLE);
   assign stat.pend_valid = pend_valid_ff;

endmodule
